FILE: rtl/qpsd_pkg.sv
// Shared types, byte codes and decode modes for the quoted-printable decoder.
// No dependencies; imported by every module.
`default_nettype none

package qpsd_pkg;

    localparam logic [7:0] QP_EQ    = 8'h3D;
    localparam logic [7:0] QP_CR    = 8'h0D;
    localparam logic [7:0] QP_LF    = 8'h0A;
    localparam logic [7:0] QP_SPACE = 8'h20;

    typedef logic [1:0] t_mode;

    localparam t_mode MODE_IDLE = 2'd0;
    localparam t_mode MODE_ESC  = 2'd1;
    localparam t_mode MODE_HEX1 = 2'd2;
    localparam t_mode MODE_CR   = 2'd3;

    // Outcome of one decode step.
    typedef struct packed {
        logic       emit;
        logic [7:0] value;
        logic       bad;
    } t_step_res;

    // Hex digit value in the low nibble; bit 4 set when not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        v = 5'h10;
        case (b) inside
            [8'h30:8'h39]: v = {1'b0, b[3:0]};
            [8'h41:8'h46],
            [8'h61:8'h66]: v = {1'b0, b[3:0] + 4'd9};
            default:       v = 5'h10;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/qpsd_if.sv
// Stream channels of the quoted-printable decoder: encoded input and decoded output.
// Depends on nothing but the valid/ready handshake convention.
`default_nettype none

interface qpsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_range;

    modport source (output valid, output data_byte, output end_of_range, input ready);
    modport sink   (input valid, input data_byte, input end_of_range, output ready);
endinterface

interface qpsd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] decoded_byte;
    logic       malformed;

    modport source (output valid, output decoded_byte, output malformed, input ready);
    modport sink   (input valid, input decoded_byte, input malformed, output ready);
endinterface

`default_nettype wire

FILE: rtl/qpsd_decode.sv
// Decode step: mode and held nibble registers plus the per-byte next-state logic.
// Depends on qpsd_pkg.
`default_nettype none

module qpsd_decode
    import qpsd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_take,
    input  wire logic [7:0] i_data,
    input  wire logic       i_end,
    output t_step_res       o_res,
    output t_mode           o_mode
);

    t_mode      r_mode, n_mode;
    logic [3:0] r_nib, n_nib;
    logic [4:0] hv;
    logic       plain;

    always_comb begin
        hv     = hex_value(i_data);
        n_mode = r_mode;
        n_nib  = r_nib;
        plain  = 1'b0;
        o_res  = '{emit: 1'b0, value: QP_SPACE, bad: 1'b1};
        case (r_mode)
            MODE_ESC: begin
                if (i_data == QP_CR || i_data == QP_LF) begin
                    if (i_end) begin
                        n_mode     = MODE_IDLE;
                        o_res.emit = 1'b1;
                    end else begin
                        n_mode = (i_data == QP_CR) ? MODE_CR : MODE_IDLE;
                    end
                end else if (hv[4] || i_end) begin
                    n_mode     = MODE_IDLE;
                    o_res.emit = 1'b1;
                end else begin
                    n_nib  = hv[3:0];
                    n_mode = MODE_HEX1;
                end
            end
            MODE_HEX1: begin
                n_mode     = MODE_IDLE;
                o_res.emit = 1'b1;
                if (!hv[4]) begin
                    o_res.value = {r_nib, hv[3:0]};
                    o_res.bad   = 1'b0;
                end
            end
            MODE_CR: begin
                if (i_data == QP_LF) begin
                    n_mode     = MODE_IDLE;
                    o_res.emit = i_end;
                end else begin
                    plain = 1'b1;
                end
            end
            default: plain = 1'b1;
        endcase

        // ordinary byte, the start of a new escape, or a lone '=' on the last beat of a range
        if (plain) begin
            n_mode = MODE_IDLE;
            if (i_data != QP_EQ) begin
                o_res = '{emit: 1'b1, value: i_data, bad: 1'b0};
            end else if (i_end) begin
                o_res.emit = 1'b1;
            end else begin
                n_mode = MODE_ESC;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_nib  <= 4'd0;
        end else if (i_take) begin
            r_mode <= n_mode;
            r_nib  <= n_nib;
        end
    end

    assign o_mode = r_mode;

endmodule

`default_nettype wire

FILE: rtl/quoted_printable_stream_decoder_top.sv
// Quoted-printable stream decoder: input register, decode step, result register.
// An accepted byte is held in the input register, and its decode result in the result register.
// Throughput: one byte per cycle while the output is not stalled; set by the single
// decode step between the two registers, whose mode register is updated once per byte.
// Reset: synchronous, active low; empties both registers and returns the mode to idle.
// Depends on qpsd_pkg, qpsd_if and qpsd_decode.
`default_nettype none

module quoted_printable_stream_decoder_top
    import qpsd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    qpsd_in_if.sink      i_qp,
    qpsd_out_if.source   o_qp
);

    logic       r_in_valid;
    logic [7:0] r_in_data;
    logic       r_in_end;
    logic       r_out_valid;
    logic [7:0] r_out_data;
    logic       r_out_bad;
    logic       adv;
    t_step_res  res;
    t_mode      mode;

    // advance the held beat whenever the result register is free or draining
    assign adv        = r_in_valid && (!r_out_valid || o_qp.ready);
    assign i_qp.ready = !r_in_valid || adv;

    qpsd_decode u_decode (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_take (adv),
        .i_data (r_in_data),
        .i_end  (r_in_end),
        .o_res  (res),
        .o_mode (mode)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_qp.ready) begin
            r_in_valid <= i_qp.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_qp.valid && i_qp.ready) begin
            r_in_data <= i_qp.data_byte;
            r_in_end  <= i_qp.end_of_range;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= res.emit;
        end else if (o_qp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && res.emit) begin
            r_out_data <= res.value;
            r_out_bad  <= res.bad;
        end
    end

    assign o_qp.valid        = r_out_valid;
    assign o_qp.decoded_byte = r_out_data;
    assign o_qp.malformed    = r_out_bad;

    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_end) |=> (mode == MODE_IDLE))
        else $error("mode not idle after last beat of range");

    a_bad_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_bad) |-> (r_out_data == QP_SPACE))
        else $error("malformed result is not a space");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !adv) |=> (r_in_valid && $stable(r_in_data) && $stable(r_in_end)))
        else $error("held input beat lost or overwritten");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_qp.ready) |=> (r_out_valid && $stable(r_out_data)))
        else $error("stalled result dropped");

endmodule

`default_nettype wire
